// ===== rtl/lclt_pkg.sv =====
package lclt_pkg;

  // Signed coordinate wide enough for a run end plus a full walk of 255 cells
  localparam int CRD_W  = 12;
  // APB address bits for seven word-spaced registers
  localparam int CFG_AW = 5;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam logic [1:0] DIR_POS_X = 2'd0;
  localparam logic [1:0] DIR_POS_Y = 2'd1;
  localparam logic [1:0] DIR_NEG_X = 2'd2;
  localparam logic [1:0] DIR_NEG_Y = 2'd3;

  typedef struct packed {
    logic [8:0]  eff_width;
    logic [8:0]  eff_height;
    logic [15:0] level;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [1:0]  start_dir;
    logic [7:0]  start_len;
    logic        reload;
  } cfg_t;

  typedef struct packed {
    logic valid;
    crd_t x;
    crd_t y;
  } probe_req_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } probe_rsp_t;

  function automatic crd_t step_dx(input logic [1:0] dir);
    case (dir)
      DIR_POS_X: return crd_t'(1);
      DIR_NEG_X: return crd_t'(-1);
      default:   return crd_t'(0);
    endcase
  endfunction

  function automatic crd_t step_dy(input logic [1:0] dir);
    case (dir)
      DIR_POS_Y: return crd_t'(1);
      DIR_NEG_Y: return crd_t'(-1);
      default:   return crd_t'(0);
    endcase
  endfunction

endpackage

// ===== rtl/lclt_if.sv =====
interface lclt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] map_addr;
  logic [15:0] map_value;

  modport source (output valid, output op, output map_addr, output map_value, input ready);
  modport sink   (input valid, input op, input map_addr, input map_value, output ready);
endinterface

interface lclt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_x;
  logic [7:0] run_y;
  logic [1:0] run_dir;
  logic [8:0] run_cells;

  modport source (output valid, output run_x, output run_y, output run_dir, output run_cells,
                  input ready);
  modport sink   (input valid, input run_x, input run_y, input run_dir, input run_cells,
                  output ready);
endinterface

// ===== rtl/level_contour_line_tracer_unit.sv =====
// Boundary tracer over a distance map held in a 64K-word RAM. Write transactions
// (op 0) store one map word, and the port stays ready for the next. A step transaction (op 1)
// returns the current run and moves the tracer to the next one: the input is held off while
// the tracer probes the diagonal cell and then walks the new run cell by cell (the walk stops
// at 255 extra cells), and while it waits for a full output register. The shared cell probe,
// an address multiply, a registered RAM read and a level compare, is used twice per walked
// cell, and the walk sets how long the input is held off. The result leaves through an output
// register, so a finished run may wait for the sink while further writes are taken. Writing
// any start register reloads the tracer; the port is busy for that one cycle.
module level_contour_line_tracer_unit import lclt_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DIST_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lclt_in_if.sink           in_i,
  lclt_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIAG,
    ST_DIAG_W,
    ST_SETUP,
    ST_CELL,
    ST_LEFT,
    ST_CELL_W,
    ST_LEFT_W,
    ST_EMIT
  } state_e;

  cfg_t       cfg;
  probe_req_t probe_req;
  probe_rsp_t probe_rsp;

  state_e     state_q;
  logic [7:0] edge_col_q, edge_row_q, edge_extra_q;
  logic [1:0] edge_dir_q;
  crd_t       end_x_q, end_y_q, cur_x_q, cur_y_q;
  logic [1:0] dir_q;
  logic [7:0] cnt_q;
  logic       cell_in_q;
  logic [7:0] hold_x_q, hold_y_q;
  logic [1:0] hold_dir_q;
  logic [8:0] hold_cells_q;
  logic       out_valid_q;
  logic [7:0] out_x_q, out_y_q;
  logic [1:0] out_dir_q;
  logic [8:0] out_cells_q;

  logic       in_fire, wr_en;
  crd_t       dx, dy, diag_x, diag_y;
  crd_t       len_s, run_end_x, run_end_y;

  lclt_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lclt_probe #(
    .DIST_BITS (DIST_BITS)
  ) u_probe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (probe_req),
    .wr_en_i    (wr_en),
    .wr_addr_i  (in_i.map_addr),
    .wr_value_i (in_i.map_value),
    .rsp_o      (probe_rsp)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !cfg.reload;
  assign in_fire    = in_i.valid && in_i.ready;
  assign wr_en      = in_fire && (in_i.op == OP_WRITE);

  assign dx     = step_dx(dir_q);
  assign dy     = step_dy(dir_q);
  assign diag_x = end_x_q + dx - dy;
  assign diag_y = end_y_q + dy + dx;

  // far end of the current run
  assign len_s = crd_t'(edge_extra_q);
  always_comb begin
    run_end_x = crd_t'(edge_col_q);
    run_end_y = crd_t'(edge_row_q);
    case (edge_dir_q)
      DIR_POS_X: run_end_x = crd_t'(edge_col_q) + len_s;
      DIR_POS_Y: run_end_y = crd_t'(edge_row_q) + len_s;
      DIR_NEG_X: run_end_x = crd_t'(edge_col_q) - len_s;
      DIR_NEG_Y: run_end_y = crd_t'(edge_row_q) - len_s;
      default: ;
    endcase
  end

  always_comb begin
    probe_req = '{valid: 1'b0, x: cur_x_q, y: cur_y_q};
    case (state_q)
      ST_DIAG: probe_req = '{valid: 1'b1, x: diag_x, y: diag_y};
      ST_CELL: probe_req.valid = (cnt_q != 8'hFF);
      ST_LEFT: probe_req = '{valid: 1'b1, x: cur_x_q - dy, y: cur_y_q + dx};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_col_q   <= '0;
      edge_row_q   <= '0;
      edge_dir_q   <= '0;
      edge_extra_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.reload) begin
        edge_col_q   <= cfg.start_x;
        edge_row_q   <= cfg.start_y;
        edge_dir_q   <= cfg.start_dir;
        edge_extra_q <= cfg.start_len;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_i.op == OP_STEP)) begin
            hold_x_q     <= edge_col_q;
            hold_y_q     <= edge_row_q;
            hold_dir_q   <= edge_dir_q;
            hold_cells_q <= 9'(edge_extra_q) + 9'd1;
            end_x_q      <= run_end_x;
            end_y_q      <= run_end_y;
            dir_q        <= edge_dir_q;
            state_q      <= ST_DIAG;
          end
        end
        ST_DIAG: state_q <= ST_DIAG_W;
        ST_DIAG_W: begin
          if (probe_rsp.valid) begin
            if (probe_rsp.hit) begin
              end_x_q <= diag_x;
              end_y_q <= diag_y;
              dir_q   <= dir_q + 2'd1;
            end else begin
              dir_q   <= dir_q - 2'd1;
            end
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cur_x_q <= end_x_q + dx;
          cur_y_q <= end_y_q + dy;
          cnt_q   <= '0;
          state_q <= ST_CELL;
        end
        ST_CELL: begin
          if (cnt_q == 8'hFF) begin
            edge_col_q   <= end_x_q[7:0];
            edge_row_q   <= end_y_q[7:0];
            edge_dir_q   <= dir_q;
            edge_extra_q <= cnt_q;
            state_q      <= ST_EMIT;
          end else begin
            state_q <= ST_LEFT;
          end
        end
        ST_LEFT: state_q <= ST_CELL_W;
        ST_CELL_W: begin
          if (probe_rsp.valid) begin
            cell_in_q <= probe_rsp.hit;
            state_q   <= ST_LEFT_W;
          end
        end
        ST_LEFT_W: begin
          if (probe_rsp.valid) begin
            if (cell_in_q && !probe_rsp.hit) begin
              // advance along the edge
              cur_x_q <= cur_x_q + dx;
              cur_y_q <= cur_y_q + dy;
              cnt_q   <= cnt_q + 8'd1;
              state_q <= ST_CELL;
            end else begin
              edge_col_q   <= end_x_q[7:0];
              edge_row_q   <= end_y_q[7:0];
              edge_dir_q   <= dir_q;
              edge_extra_q <= cnt_q;
              state_q      <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_x_q     <= hold_x_q;
            out_y_q     <= hold_y_q;
            out_dir_q   <= hold_dir_q;
            out_cells_q <= hold_cells_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.run_x     = out_x_q;
  assign out_o.run_y     = out_y_q;
  assign out_o.run_dir   = out_dir_q;
  assign out_o.run_cells = out_cells_q;

  a_rsp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe_rsp.valid |-> (state_q == ST_DIAG_W || state_q == ST_CELL_W || state_q == ST_LEFT_W))
    else $error("probe response outside a wait state");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit");

  a_cells_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cells_q != 9'd0))
    else $error("empty run emitted");

endmodule

// ===== rtl/lclt_cfg.sv =====
module lclt_cfg import lclt_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  typedef enum logic [2:0] {
    REG_MAP_WIDTH,
    REG_MAP_HEIGHT,
    REG_TRACE_LEVEL,
    REG_START_X,
    REG_START_Y,
    REG_START_DIR,
    REG_START_LEN
  } reg_e;

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int cap);
    if (v == 9'd0) return 9'd1;
    if (int'(v) > cap) return 9'(cap);
    return v;
  endfunction

  logic [8:0]  width_q, height_q, effw_q, effh_q;
  logic [15:0] level_q;
  logic [7:0]  sx_q, sy_q, slen_q;
  logic [1:0]  sdir_q;
  logic        reload_q;
  logic        wr_en;
  logic        start_wr;
  reg_e        reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en    = psel && penable && pwrite;
  assign start_wr = wr_en && (reg_idx == REG_START_X || reg_idx == REG_START_Y ||
                              reg_idx == REG_START_DIR || reg_idx == REG_START_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      effw_q   <= clamp_dim(9'd256, MAX_WIDTH);
      effh_q   <= clamp_dim(9'd256, MAX_HEIGHT);
      level_q  <= 16'd1;
      sx_q     <= '0;
      sy_q     <= '0;
      sdir_q   <= '0;
      slen_q   <= '0;
      reload_q <= 1'b0;
    end else begin
      reload_q <= start_wr;
      if (wr_en) begin
        case (reg_idx)
          REG_MAP_WIDTH: begin
            width_q <= pwdata[8:0];
            effw_q  <= clamp_dim(pwdata[8:0], MAX_WIDTH);
          end
          REG_MAP_HEIGHT: begin
            height_q <= pwdata[8:0];
            effh_q   <= clamp_dim(pwdata[8:0], MAX_HEIGHT);
          end
          REG_TRACE_LEVEL: level_q <= pwdata[15:0];
          REG_START_X:     sx_q    <= pwdata[7:0];
          REG_START_Y:     sy_q    <= pwdata[7:0];
          REG_START_DIR:   sdir_q  <= pwdata[1:0];
          REG_START_LEN:   slen_q  <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAP_WIDTH:   prdata = 32'(width_q);
      REG_MAP_HEIGHT:  prdata = 32'(height_q);
      REG_TRACE_LEVEL: prdata = 32'(level_q);
      REG_START_X:     prdata = 32'(sx_q);
      REG_START_Y:     prdata = 32'(sy_q);
      REG_START_DIR:   prdata = 32'(sdir_q);
      REG_START_LEN:   prdata = 32'(slen_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.eff_width  = effw_q;
  assign cfg_o.eff_height = effh_q;
  assign cfg_o.level      = level_q;
  assign cfg_o.start_x    = sx_q;
  assign cfg_o.start_y    = sy_q;
  assign cfg_o.start_dir  = sdir_q;
  assign cfg_o.start_len  = slen_q;
  assign cfg_o.reload     = reload_q;

endmodule

// ===== rtl/lclt_probe.sv =====
module lclt_probe import lclt_pkg::*; #(
  parameter int DIST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  probe_req_t  req_i,
  input  logic        wr_en_i,
  input  logic [15:0] wr_addr_i,
  input  logic [15:0] wr_value_i,
  output probe_rsp_t  rsp_o
);

  localparam int MapDepth = 65536;

  logic [DIST_BITS-1:0] dmap_mem [MapDepth];

  logic                 s1_valid_q, s1_inb_q;
  logic [15:0]          s1_addr_q;
  logic                 s2_valid_q, s2_inb_q;
  logic [DIST_BITS-1:0] s2_data_q;

  logic                 inb;
  logic [8:0]           col, row;
  logic [17:0]          prod;
  logic [15:0]          addr;
  logic [31:0]          wr_wide;
  logic [31:0]          cell_val;

  assign col  = req_i.x[8:0];
  assign row  = req_i.y[8:0];
  assign inb  = !req_i.x[CRD_W-1] && !req_i.y[CRD_W-1]
             && (req_i.x[CRD_W-2:0] < (CRD_W-1)'(cfg_i.eff_width))
             && (req_i.y[CRD_W-2:0] < (CRD_W-1)'(cfg_i.eff_height));
  assign prod = row * cfg_i.eff_width;
  // index wraps to the store's 16-bit address
  assign addr = 16'(prod + 18'(col));

  assign wr_wide = 32'(wr_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr;
    s1_inb_q  <= inb;
    s2_inb_q  <= s1_inb_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      dmap_mem[wr_addr_i] <= wr_wide[DIST_BITS-1:0];
    end
    s2_data_q <= dmap_mem[s1_addr_q];
  end

  // cells off the map read as zero
  assign cell_val     = s2_inb_q ? 32'(s2_data_q) : 32'd0;
  assign rsp_o.valid  = s2_valid_q;
  assign rsp_o.hit    = cell_val >= 32'(cfg_i.level);

endmodule

// ===== test/tb_level_contour_line_tracer_unit.sv =====
typedef enum logic {
  OP_LOAD = 1'b0,
  OP_STEP = 1'b1
} map_op_e;

typedef enum int {
  REG_MAP_WIDTH   = 0,
  REG_MAP_HEIGHT  = 1,
  REG_TRACE_LEVEL = 2,
  REG_START_X     = 3,
  REG_START_Y     = 4,
  REG_START_DIR   = 5,
  REG_START_LEN   = 6,
  REG_UNMAPPED    = 7
} cfg_reg_e;

typedef struct packed {
  logic [7:0] x;
  logic [7:0] y;
  logic [1:0] dir;
  logic [8:0] cells;
} contour_run_t;

class contour_tracker;
  localparam int DIM_MAX = 256;

  logic [15:0]  dist_map [65536];
  logic [8:0]   width_reg;
  logic [8:0]   height_reg;
  logic [15:0]  level_reg;
  logic [7:0]   start_col;
  logic [7:0]   start_row;
  logic [1:0]   start_heading;
  logic [7:0]   start_span;
  logic [7:0]   edge_col;
  logic [7:0]   edge_row;
  logic [1:0]   edge_dir;
  logic [7:0]   edge_extra;
  contour_run_t runs_due [$];
  int           runs_checked;
  int           errors;

  function new();
    width_reg     = 9'd256;
    height_reg    = 9'd256;
    level_reg     = 16'd1;
    start_col     = '0;
    start_row     = '0;
    start_heading = lclt_pkg::DIR_POS_X;
    start_span    = '0;
    runs_checked  = 0;
    errors        = 0;
    reload_edge();
  endfunction

  function int dim_in_use(int r);
    if (r < 1) return 1;
    if (r > DIM_MAX) return DIM_MAX;
    return r;
  endfunction

  function void reload_edge();
    edge_col   = start_col;
    edge_row   = start_row;
    edge_dir   = start_heading;
    edge_extra = start_span;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [31:0] v);
    case (idx)
      REG_MAP_WIDTH:   width_reg = v[8:0];
      REG_MAP_HEIGHT:  height_reg = v[8:0];
      REG_TRACE_LEVEL: level_reg = v[15:0];
      REG_START_X: begin
        start_col = v[7:0];
        reload_edge();
      end
      REG_START_Y: begin
        start_row = v[7:0];
        reload_edge();
      end
      REG_START_DIR: begin
        start_heading = v[1:0];
        reload_edge();
      end
      REG_START_LEN: begin
        start_span = v[7:0];
        reload_edge();
      end
      default: ;
    endcase
  endfunction

  function void heading_step(logic [1:0] d, output int dc, output int dr);
    dc = 0;
    dr = 0;
    case (d)
      lclt_pkg::DIR_POS_X: dc = 1;
      lclt_pkg::DIR_NEG_X: dc = -1;
      lclt_pkg::DIR_POS_Y: dr = 1;
      default:             dr = -1;
    endcase
  endfunction

  // Cells off the map read as zero
  function bit is_inside(int x, int y);
    int w;
    int h;
    logic [15:0] v;
    w = dim_in_use(int'(width_reg));
    h = dim_in_use(int'(height_reg));
    if (x < 0 || y < 0 || x >= w || y >= h) v = '0;
    else v = dist_map[(y * w + x) & 16'hFFFF];
    return v >= level_reg;
  endfunction

  // Move to the end of the current run, turn, and count the next run
  function void follow_edge();
    int dir;
    int dc;
    int dr;
    int x0;
    int y0;
    int x1;
    int y1;
    int n;
    dir = int'(edge_dir);
    heading_step(2'(dir), dc, dr);
    x0 = int'(edge_col) + dc * int'(edge_extra);
    y0 = int'(edge_row) + dr * int'(edge_extra);
    if (is_inside(x0 + dc - dr, y0 + dr + dc)) begin
      x0 = x0 + dc - dr;
      y0 = y0 + dr + dc;
      dir = (dir + 1) % 4;
    end else begin
      dir = (dir + 3) % 4;
    end
    heading_step(2'(dir), dc, dr);
    x1 = x0 + dc;
    y1 = y0 + dr;
    n = 0;
    while (n < 255 && is_inside(x1, y1) && !is_inside(x1 - dr, y1 + dc)) begin
      x1 += dc;
      y1 += dr;
      n++;
    end
    edge_col   = 8'(x0);
    edge_row   = 8'(y0);
    edge_dir   = 2'(dir);
    edge_extra = 8'(n);
  endfunction

  function void accept_item(logic op, logic [15:0] addr, logic [15:0] value);
    contour_run_t r;
    if (op == OP_LOAD) begin
      dist_map[addr] = value;
    end else begin
      r.x     = edge_col;
      r.y     = edge_row;
      r.dir   = edge_dir;
      r.cells = 9'(edge_extra) + 9'd1;
      runs_due.push_back(r);
      follow_edge();
    end
  endfunction

  task report(string line);
    errors++;
    if (errors <= 100) $display("ERROR: %s", line);
  endtask

  task check_run(contour_run_t got);
    contour_run_t want;
    if (runs_due.size() == 0) begin
      report($sformatf("run %0d arrived with none pending", runs_checked));
    end else begin
      want = runs_due.pop_front();
      if (got.x !== want.x)
        report($sformatf("run %0d run_x %0d, expected %0d", runs_checked, got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("run %0d run_y %0d, expected %0d", runs_checked, got.y, want.y));
      if (got.dir !== want.dir)
        report($sformatf("run %0d run_dir %0d, expected %0d", runs_checked, got.dir, want.dir));
      if (got.cells !== want.cells)
        report($sformatf("run %0d run_cells %0d, expected %0d", runs_checked, got.cells,
                         want.cells));
    end
    runs_checked++;
  endtask
endclass

module tb_level_contour_line_tracer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lclt_pkg::*;

  localparam int    ITEM_TARGET   = 1450;
  localparam int    SETTLE_CYCLES = 1100;
  localparam int    HOLD_CYCLES   = 600;
  localparam longint TIMEOUT_NS   = 40_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lclt_in_if  in_if ();
  lclt_out_if out_if ();

  contour_tracker tracker = new();
  int             items_sent = 0;
  bit             send_calm = 1'b0;
  bit             sink_calm = 1'b0;

  level_contour_line_tracer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tracker.accept_item(in_if.op, in_if.map_addr, in_if.map_value);
      end
      if (out_if.valid && out_if.ready) begin
        tracker.check_run('{x: out_if.run_x, y: out_if.run_y, dir: out_if.run_dir,
                            cells: out_if.run_cells});
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] level_value(logic [15:0] lvl, int pct);
    if (lvl == 16'd0) return 16'($urandom);
    if ($urandom_range(0, 99) < pct) return 16'($urandom_range(int'(lvl), 65535));
    return 16'($urandom_range(0, int'(lvl) - 1));
  endfunction

  function automatic int pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 255;
    return $urandom_range(0, 255);
  endfunction

  // Enter and leave at a falling edge; valid stays high between back-to-back transactions
  task automatic send_item(map_op_e op, logic [15:0] addr, logic [15:0] value);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.op        = op;
    in_if.map_addr  = addr;
    in_if.map_value = value;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_step();
    send_item(OP_STEP, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain(int settle);
    in_if.valid = 1'b0;
    while (tracker.runs_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_AW'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wait out the last walk before touching the registers
  task automatic configure(int w_reg, int h_reg, logic [15:0] lvl, int sx, int sy,
                           logic [1:0] sdir, int slen);
    drain(SETTLE_CYCLES);
    write_reg(REG_MAP_WIDTH, w_reg);
    write_reg(REG_MAP_HEIGHT, h_reg);
    write_reg(REG_TRACE_LEVEL, lvl);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_DIR, sdir);
    write_reg(REG_START_LEN, slen);
  endtask

  task automatic run_phase(int w_reg, int h_reg, logic [15:0] lvl, int pct, int sx, int sy,
                           logic [1:0] sdir, int slen, int n_ops, bit pause_mid);
    int cells;
    configure(w_reg, h_reg, lvl, sx, sy, sdir, slen);
    send_calm = ($urandom_range(0, 3) == 0);
    cells = tracker.dim_in_use(w_reg) * tracker.dim_in_use(h_reg);
    // Load every cell in use so that no walk reads an unwritten word
    for (int i = 0; i < cells; i++) send_item(OP_LOAD, 16'(i), level_value(lvl, pct));
    for (int k = 0; k < n_ops; k++) begin
      if (pause_mid && k == n_ops / 2) drain(0);
      if ($urandom_range(0, 99) < 55) send_step();
      else if ($urandom_range(0, 99) < 80)
        send_item(OP_LOAD, 16'($urandom_range(0, cells - 1)), level_value(lvl, pct));
      else send_item(OP_LOAD, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin : result_sink
    int gap;
    int hold_at;
    hold_at = 40;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // Hold off for a long stretch while a run waits, so that the block backs up
      if (tracker.runs_checked >= hold_at && out_if.valid) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_at = (hold_at < 250) ? 250 : 32'h7FFF_FFFF;
      end
      if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
    end
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int r;
    int w_reg;
    int h_reg;
    int pct;
    int sx;
    int sy;
    int slen;
    int phase_no;
    logic [15:0] lvl;
    in_if.valid     = 1'b0;
    in_if.op        = OP_LOAD;
    in_if.map_addr  = '0;
    in_if.map_value = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Small map with mixed cells, field extremes and walks off the edge
    configure(3, 2, 16'd100, 0, 0, DIR_POS_X, 0);
    send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 16'd0, 16'd0);
    send_item(OP_LOAD, 16'd1, 16'hFFFF);
    send_item(OP_LOAD, 16'd2, 16'd100);
    send_item(OP_LOAD, 16'd3, 16'd99);
    send_item(OP_LOAD, 16'd4, 16'd200);
    send_item(OP_LOAD, 16'd5, 16'd101);
    repeat (5) send_step();

    // Level zero: everything is inside
    configure(2, 2, 16'd0, 1, 0, DIR_NEG_Y, 1);
    for (int i = 0; i < 4; i++) send_item(OP_LOAD, 16'(i), 16'($urandom));
    repeat (3) send_step();

    // Zero sizes saturate to a single cell; top level, longest start run
    configure(0, 0, 16'hFFFF, 0, 0, DIR_NEG_X, 255);
    send_item(OP_LOAD, 16'd0, 16'hFFFF);
    repeat (3) send_step();
    drain(SETTLE_CYCLES);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

    // Full-width strip, oversized width register: the second run spans the whole row
    run_phase(511, 1, 16'd1, 100, 0, 0, DIR_POS_Y, 0, 20, 1'b1);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        w_reg = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
        h_reg = 1;
        pct   = 85;
      end else if (kind < 10) begin
        w_reg = 1;
        h_reg = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
        pct   = 85;
      end else begin
        w_reg = $urandom_range(1, 12);
        h_reg = $urandom_range(1, 12);
        pct   = $urandom_range(25, 75);
      end
      r = $urandom_range(0, 99);
      if (r < 10) lvl = 16'd1;
      else if (r < 14) lvl = 16'd0;
      else if (r < 20) lvl = 16'hFFFF;
      else lvl = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 99) < 85) begin
        sx   = $urandom_range(0, tracker.dim_in_use(w_reg) - 1);
        sy   = $urandom_range(0, tracker.dim_in_use(h_reg) - 1);
        slen = $urandom_range(0, 3);
      end else begin
        sx   = pick_byte();
        sy   = pick_byte();
        slen = pick_byte();
      end
      run_phase(w_reg, h_reg, lvl, pct, sx, sy, 2'($urandom), slen, $urandom_range(30, 90),
                phase_no == 1 || $urandom_range(0, 9) == 0);
      phase_no++;
    end

    drain(SETTLE_CYCLES);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/lclt_pkg.sv
rtl/lclt_if.sv
rtl/lclt_cfg.sv
rtl/lclt_probe.sv
rtl/level_contour_line_tracer_unit.sv
test/tb_level_contour_line_tracer_unit.sv
